>>> hdl/strev_pkg.sv
// shared types, constants and tap tables for the sparse tap reverb
package strev_pkg;

  localparam int TABLE_LEN = 82;
  localparam int TAP_IDX_W = 7;
  localparam int X_ORIGIN  = 52;
  localparam int Y_ORIGIN  = 1362;
  localparam int Y_SPAN    = 709;
  localparam int SEEN_BASE = 2502;
  localparam int BASE_W    = 12;
  localparam int SMP_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int WT_W      = 16;
  localparam int LO_W      = 20;
  localparam int RND_SH    = 28;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  typedef enum logic [1:0] {
    REG_STEREO  = 2'd0,
    REG_STRETCH = 2'd1,
    REG_GAIN    = 2'd2
  } reg_idx_t;

  typedef logic [BASE_W-1:0] tap_base_t [TABLE_LEN];
  typedef logic [WT_W-1:0]   tap_wt_t   [TABLE_LEN];

  typedef struct packed {
    logic                 accept;
    logic                 issue;
    logic [TAP_IDX_W-1:0] tap;
    logic                 mul;
    logic                 add;
    logic                 load;
  } strev_cmd_t;

  localparam logic [11:0] TAP_X [TABLE_LEN] = '{
    12'd193,  12'd334,  12'd447,  12'd571,  12'd620,  12'd661,  12'd681,  12'd702,
    12'd733,  12'd761,  12'd781,  12'd816,  12'd843,  12'd878,  12'd919,  12'd936,
    12'd950,  12'd988,  12'd1009, 12'd1029, 12'd1063, 12'd1074, 12'd1109, 12'd1126,
    12'd1156, 12'd1177, 12'd1198, 12'd1218, 12'd1229, 12'd1243, 12'd1263, 12'd1290,
    12'd1311, 12'd1339, 12'd1363, 12'd1397, 12'd1425, 12'd1460, 12'd1480, 12'd1514,
    12'd1545, 12'd1566, 12'd1594, 12'd1614, 12'd1645, 12'd1680, 12'd1697, 12'd1724,
    12'd1748, 12'd1778, 12'd1804, 12'd1831, 12'd1872, 12'd1914, 12'd1938, 12'd1965,
    12'd1976, 12'd1999, 12'd2020, 12'd2048, 12'd2062, 12'd2089, 12'd2113, 12'd2134,
    12'd2155, 12'd2179, 12'd2199, 12'd2220, 12'd2240, 12'd2268, 12'd2282, 12'd2303,
    12'd2327, 12'd2344, 12'd2368, 12'd2371, 12'd2409, 12'd2427, 12'd2457, 12'd2495,
    12'd2516, 12'd2554
  };

  localparam logic [10:0] TAP_Y [TABLE_LEN] = '{
    11'd653,  11'd739,  11'd756,  11'd843,  11'd901,  11'd928,  11'd908,  11'd915,
    11'd990,  11'd908,  11'd994,  11'd977,  11'd1001, 11'd956,  11'd1021, 11'd1101,
    11'd1056, 11'd1077, 11'd1035, 11'd1097, 11'd1063, 11'd1097, 11'd1114, 11'd1201,
    11'd1114, 11'd1080, 11'd1184, 11'd1135, 11'd1128, 11'd1201, 11'd1128, 11'd1197,
    11'd1235, 11'd1170, 11'd1142, 11'd1190, 11'd1224, 11'd1190, 11'd1235, 11'd1180,
    11'd1201, 11'd1283, 11'd1256, 11'd1190, 11'd1201, 11'd1263, 11'd1211, 11'd1245,
    11'd1290, 11'd1304, 11'd1263, 11'd1283, 11'd1280, 11'd1304, 11'd1304, 11'd1304,
    11'd1283, 11'd1311, 11'd1311, 11'd1294, 11'd1311, 11'd1297, 11'd1304, 11'd1280,
    11'd1297, 11'd1311, 11'd1311, 11'd1311, 11'd1297, 11'd1318, 11'd1318, 11'd1324,
    11'd1331, 11'd1331, 11'd1331, 11'd1331, 11'd1324, 11'd1324, 11'd1324, 11'd1324,
    11'd1324, 11'd1335
  };

  function automatic tap_base_t build_base();
    tap_base_t b;
    for (int k = 0; k < TABLE_LEN; k++) begin
      b[k] = BASE_W'(int'(TAP_X[k]) - X_ORIGIN);
    end
    return b;
  endfunction

  // q0.16 weights, rounded to nearest, full scale held as all ones
  function automatic tap_wt_t build_weights();
    tap_wt_t     w;
    int unsigned q;
    for (int k = 0; k < TABLE_LEN; k++) begin
      q = ((unsigned'(Y_ORIGIN - int'(TAP_Y[k])) << 16) + Y_SPAN / 2) / Y_SPAN;
      w[k] = (q > 32'd65535) ? 16'hFFFF : q[15:0];
    end
    return w;
  endfunction

  localparam tap_base_t TAP_BASE = build_base();
  localparam tap_wt_t   TAP_WT   = build_weights();

endpackage

>>> hdl/strev_ram.sv
// generic simple dual port ram with registered read
module strev_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/strev_ctrl.sv
// controller state machine sequencing taps, product and result hand-off
module strev_ctrl #(
  parameter int TAP_COUNT = 82
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output strev_pkg::strev_cmd_t cmd
);
  import strev_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam int DRAIN_CYC = 3;

  state_t               state_r, state_nxt;
  logic [TAP_IDX_W-1:0] tap_r, tap_nxt;
  logic [1:0]           drain_r, drain_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.tap       = tap_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          tap_nxt    = '0;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (tap_r == TAP_IDX_W'(TAP_COUNT - 1)) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_r == 2'(DRAIN_CYC - 1)) begin
          state_nxt = ST_MUL;
        end else begin
          drain_nxt = drain_r + 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hdl/strev_dp.sv
// datapath: history rings, tap address pipeline, mac, gain product, saturation
module strev_dp #(
  parameter int TAP_COUNT     = 82,
  parameter int MAX_STRETCH   = 6,
  parameter int HISTORY_DEPTH = 16384
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  strev_pkg::strev_cmd_t       cmd,
  input  logic                        stereo,
  input  logic [2:0]                  stretch,
  input  logic [strev_pkg::GAIN_W-1:0] gain,
  input  logic signed [strev_pkg::SMP_W-1:0] left_in,
  input  logic signed [strev_pkg::SMP_W-1:0] right_in,
  input  logic                        start_flag,
  output logic signed [strev_pkg::SMP_W-1:0] left_out,
  output logic signed [strev_pkg::SMP_W-1:0] right_out
);
  import strev_pkg::*;

  localparam int AW       = $clog2(HISTORY_DEPTH);
  localparam int FW       = $clog2(MAX_STRETCH + 1);
  localparam int SEEN_CAP = SEEN_BASE * MAX_STRETCH;
  localparam int SEEN_W   = $clog2(SEEN_CAP + 1);
  localparam int OFF_W    = BASE_W + FW;
  localparam int PROD_W   = WT_W + SMP_W + 1;
  localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT);
  localparam int HI_W     = ACC_W - LO_W;
  localparam int PLO_W    = LO_W + GAIN_W;
  localparam int PHI_W    = HI_W + GAIN_W + 1;
  localparam int FULL_W   = ACC_W + GAIN_W + 1;
  localparam int RV_W     = FULL_W - RND_SH;
  localparam int SUM_W    = RV_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

  // sequence state
  logic [AW-1:0]     wp_r, cur_r;
  logic [SEEN_W-1:0] seen_r, idx_r, idx_nxt;
  logic [FW-1:0]     fac_r, fac_nxt;
  logic              stereo_r;
  logic signed [SMP_W-1:0] smp_r [2];
  logic [SMP_W-1:0]  right_wr;

  // tap pipeline
  logic              v0_r, v1_r, v2_r, en1;
  logic [OFF_W-1:0]  off0_r;
  logic [WT_W-1:0]   w0_r, w1_r;
  logic [AW:0]       diff;
  logic [AW-1:0]     raddr;
  logic [SMP_W-1:0]  rd [2];
  logic signed [PROD_W-1:0] prod_r [2];
  logic signed [ACC_W-1:0]  acc_r [2];
  logic [PLO_W-1:0]         plo_r [2];
  logic signed [PHI_W-1:0]  phi_r [2];
  logic signed [RV_W-1:0]   rv_r [2];
  logic signed [FULL_W-1:0] full [2];
  logic signed [SUM_W-1:0]  sum [2];
  logic signed [SMP_W-1:0]  sat [2];
  logic signed [SMP_W-1:0]  out_r [2];

  always_comb begin
    if (stretch == 3'd0) begin
      fac_nxt = FW'(1);
    end else if (32'(stretch) > 32'(MAX_STRETCH)) begin
      fac_nxt = FW'(MAX_STRETCH);
    end else begin
      fac_nxt = FW'(stretch);
    end
  end

  assign idx_nxt  = start_flag ? '0 : seen_r;
  assign right_wr = stereo ? right_in : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      seen_r <= '0;
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= en1;
      v2_r <= v1_r;
      if (cmd.accept) begin
        wp_r   <= (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        seen_r <= (idx_nxt < SEEN_W'(SEEN_CAP)) ? idx_nxt + 1'b1 : idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r    <= wp_r;
      idx_r    <= idx_nxt;
      fac_r    <= fac_nxt;
      stereo_r <= stereo;
      smp_r[0] <= left_in;
      smp_r[1] <= signed'(right_wr);
    end
    off0_r <= OFF_W'(TAP_BASE[cmd.tap]) * OFF_W'(fac_r);
    w0_r   <= TAP_WT[cmd.tap];
    w1_r   <= w0_r;
  end

  // tap must not reach before signal start nor past the ring
  assign en1 = v0_r && (32'(off0_r) <= 32'(idx_r)) && (32'(off0_r) < 32'(HISTORY_DEPTH));
  assign diff = (AW+1)'(cur_r) + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(off0_r);
  assign raddr = (diff >= (AW+1)'(HISTORY_DEPTH)) ? AW'(diff - (AW+1)'(HISTORY_DEPTH))
                                                 : AW'(diff);

  strev_ram #(.WIDTH(SMP_W), .DEPTH(HISTORY_DEPTH)) u_ram_left (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wp_r),
    .wdata (left_in),
    .raddr (raddr),
    .rdata (rd[0])
  );

  strev_ram #(.WIDTH(SMP_W), .DEPTH(HISTORY_DEPTH)) u_ram_right (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wp_r),
    .wdata (right_wr),
    .raddr (raddr),
    .rdata (rd[1])
  );

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      full[ch] = (FULL_W'(phi_r[ch]) <<< LO_W) + $signed(FULL_W'(plo_r[ch]))
               + $signed(FULL_W'(1) << (RND_SH - 1));
      sum[ch]  = SUM_W'(smp_r[ch]) + SUM_W'(rv_r[ch]);
      if (sum[ch] > SAT_HI) begin
        sat[ch] = SMP_W'(SAT_HI);
      end else if (sum[ch] < SAT_LO) begin
        sat[ch] = SMP_W'(SAT_LO);
      end else begin
        sat[ch] = SMP_W'(sum[ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 2; ch++) begin
      prod_r[ch] <= $signed({1'b0, w1_r}) * $signed(rd[ch]);
      if (cmd.accept) begin
        acc_r[ch] <= '0;
      end else if (v2_r) begin
        acc_r[ch] <= acc_r[ch] + ACC_W'(prod_r[ch]);
      end
      if (cmd.mul) begin
        plo_r[ch] <= PLO_W'(acc_r[ch][LO_W-1:0]) * PLO_W'(gain);
        phi_r[ch] <= $signed(acc_r[ch][ACC_W-1:LO_W]) * $signed({1'b0, gain});
      end
      if (cmd.add) begin
        rv_r[ch] <= RV_W'(full[ch] >>> RND_SH);
      end
    end
    if (cmd.load) begin
      out_r[0] <= sat[0];
      out_r[1] <= stereo_r ? sat[1] : '0;
    end
  end

  assign left_out  = out_r[0];
  assign right_out = out_r[1];

endmodule

>>> hdl/sparse_tap_reverb_core.sv
// sparse tap reverb top level: register port, controller and datapath
// requests: one at a time; in_stall holds off a new request until the result is
//   handed off; the work is one tap mac per cycle over the 82 taps through the
//   history ram read port, then drain, gain product and output
// reset: synchronous active low; clears sequencing, ring pointer, sample count
//   and registers (mono, stretch 1, gain 1.0); history ram is not cleared
module sparse_tap_reverb_core #(
  parameter int TAP_COUNT     = 82,
  parameter int MAX_STRETCH   = 6,
  parameter int HISTORY_DEPTH = 16384
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [strev_pkg::SMP_W-1:0]  in_left_in,
  input  logic signed [strev_pkg::SMP_W-1:0]  in_right_in,
  input  logic                                in_start_flag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [strev_pkg::SMP_W-1:0]  out_left_out,
  output logic signed [strev_pkg::SMP_W-1:0]  out_right_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [strev_pkg::PADDR_W-1:0]       paddr,
  input  logic [strev_pkg::PDATA_W-1:0]       pwdata,
  output logic [strev_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);
  import strev_pkg::*;

  logic              stereo_r;
  logic [2:0]        stretch_r;
  logic [GAIN_W-1:0] gain_r;
  logic              wr_en;
  reg_idx_t          reg_sel;
  strev_cmd_t        cmd;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r  <= 1'b0;
      stretch_r <= 3'd1;
      gain_r    <= GAIN_W'(4096);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_STEREO:  stereo_r  <= pwdata[0];
        REG_STRETCH: stretch_r <= pwdata[2:0];
        REG_GAIN:    gain_r    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STEREO:  prdata = PDATA_W'(stereo_r);
      REG_STRETCH: prdata = PDATA_W'(stretch_r);
      REG_GAIN:    prdata = PDATA_W'(gain_r);
      default:     prdata = '0;
    endcase
  end

  strev_ctrl #(.TAP_COUNT(TAP_COUNT)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  strev_dp #(
    .TAP_COUNT     (TAP_COUNT),
    .MAX_STRETCH   (MAX_STRETCH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stereo     (stereo_r),
    .stretch    (stretch_r),
    .gain       (gain_r),
    .left_in    (in_left_in),
    .right_in   (in_right_in),
    .start_flag (in_start_flag),
    .left_out   (out_left_out),
    .right_out  (out_right_out)
  );

endmodule

>>> hdl/strev_chk.sv
// port level checker for the sparse tap reverb core, bound to the top level
module strev_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [strev_pkg::SMP_W-1:0]  out_left_out,
  input logic signed [strev_pkg::SMP_W-1:0]  out_right_out,
  input logic                                pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_out) && $stable(out_right_out))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall) && pready)
    else $error("result appeared without a request in work");

endmodule

bind sparse_tap_reverb_core strev_chk u_chk (.*);
